@@ rtl/fgb_pkg.sv @@
// Shared widths, constants, types and the arctangent table of the bearing pipeline.
`timescale 1ns / 1ps

package fgb_pkg;

  // Field widths of the request and result channels.
  localparam int LAT_DEG_W = 8;
  localparam int LON_DEG_W = 9;
  localparam int MS_W      = 6;
  localparam int BEAR_W    = 16;

  // Number of vectoring iterations, one pipeline stage each (8 to 24).
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;

  // Arc-second values and their differences.
  localparam int ARC_W  = 22;
  localparam int DIFF_W = 23;

  // The differences enter the rotator scaled by 2^SCALE_SHIFT.
  localparam int SCALE_SHIFT = 24;
  localparam int XY_W        = DIFF_W + SCALE_SHIFT + 2;

  // Angles are in units of 2^-16 degree.
  localparam int ANG_ONE = 65536;
  localparam int Z_W     = 27;

  // Centidegree conversion.
  localparam int B_W = 28;
  localparam int P_W = 34;
  localparam int C_W = 17;

  localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * ANG_ONE);
  localparam logic signed [B_W-1:0] B_OFFSET    = B_W'((90 + 360) * ANG_ONE);
  localparam logic [P_W-1:0]        CENTI_MUL   = P_W'(100);
  localparam logic [P_W-1:0]        ROUND_HALF  = P_W'(ANG_ONE / 2);
  localparam int                    CENTI_SHIFT = 16;
  localparam logic [C_W-1:0]        FULL_TURN   = C_W'(36000);
  localparam logic [C_W-1:0]        TWO_TURNS   = C_W'(72000);
  localparam logic [BEAR_W-1:0]     BEAR_SAME   = BEAR_W'(9000);

  // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
  localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
    Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
    Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
    Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
    Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
    Z_W'(4),       Z_W'(2),       Z_W'(1),      Z_W'(0)
  };

  // One vector in flight through the rotator.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   same;
  } cordic_t;

  // Converts degrees, minutes and seconds to arc-seconds. Minutes and seconds
  // are always added, even for negative degrees.
  function automatic logic signed [ARC_W-1:0] to_arcsec(
    input logic signed [LON_DEG_W-1:0] deg,
    input logic [MS_W-1:0]             mins,
    input logic [MS_W-1:0]             secs
  );
    logic signed [ARC_W-1:0] d;
    logic signed [ARC_W-1:0] m;
    logic signed [ARC_W-1:0] s;
    d = ARC_W'(deg);
    m = signed'(ARC_W'(mins));
    s = signed'(ARC_W'(secs));
    return ARC_W'(d * ARC_W'(3600) + m * ARC_W'(60) + s);
  endfunction

endpackage

@@ rtl/fgb_if.sv @@
// Request and result channel interfaces of the bearing pipeline.
`timescale 1ns / 1ps

interface fgb_query_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fgb_pkg::LAT_DEG_W-1:0]    start_lat_deg;
  logic        [fgb_pkg::MS_W-1:0]         start_lat_min;
  logic        [fgb_pkg::MS_W-1:0]         start_lat_sec;
  logic signed [fgb_pkg::LON_DEG_W-1:0]    start_lon_deg;
  logic        [fgb_pkg::MS_W-1:0]         start_lon_min;
  logic        [fgb_pkg::MS_W-1:0]         start_lon_sec;
  logic signed [fgb_pkg::LAT_DEG_W-1:0]    goal_lat_deg;
  logic        [fgb_pkg::MS_W-1:0]         goal_lat_min;
  logic        [fgb_pkg::MS_W-1:0]         goal_lat_sec;
  logic signed [fgb_pkg::LON_DEG_W-1:0]    goal_lon_deg;
  logic        [fgb_pkg::MS_W-1:0]         goal_lon_min;
  logic        [fgb_pkg::MS_W-1:0]         goal_lon_sec;

  modport source (
    output valid, start_lat_deg, start_lat_min, start_lat_sec,
           start_lon_deg, start_lon_min, start_lon_sec,
           goal_lat_deg, goal_lat_min, goal_lat_sec,
           goal_lon_deg, goal_lon_min, goal_lon_sec,
    input  ready
  );

  modport sink (
    input  valid, start_lat_deg, start_lat_min, start_lat_sec,
           start_lon_deg, start_lon_min, start_lon_sec,
           goal_lat_deg, goal_lat_min, goal_lat_sec,
           goal_lon_deg, goal_lon_min, goal_lon_sec,
    output ready
  );
endinterface

interface fgb_result_if;
  logic                           valid;
  logic                           ready;
  logic [fgb_pkg::BEAR_W-1:0]     bearing_centideg;
  logic                           same_point;

  modport source (output valid, bearing_centideg, same_point, input ready);
  modport sink   (input valid, bearing_centideg, same_point, output ready);
endinterface

@@ rtl/flat_grid_bearing.sv @@
// Flat-grid bearing between two points through a pipelined vectoring CORDIC.
`timescale 1ns / 1ps

// Channel  Role    Carries
// query    sink    start and target latitude/longitude in degrees, minutes, seconds
// result   source  bearing in centidegrees and the identical-points flag
//
// One request enters per cycle while the result channel is not stalled; each
// passes from acceptance to its result through one register per rotator
// iteration plus the difference, pre-rotation, scaling and wrap stages.
// Reset clears the valid bits of every stage; data registers are not reset.
// Each stage holds its item while the next one is full and stalled, so a
// bubble anywhere in the pipeline is filled even while the output waits.

module flat_grid_bearing (
  input  logic                clk,
  input  logic                rst,
  fgb_query_if.sink           query,
  fgb_result_if.source        result
);
  import fgb_pkg::*;

  localparam int LAST = CORDIC_STAGES - 1;

  // Difference stage.
  logic                     a_valid;
  logic                     a_ready;
  logic signed [DIFF_W-1:0] a_dlat;
  logic signed [DIFF_W-1:0] a_dlon;
  logic                     a_same;

  // Pre-rotation stage.
  logic    p_valid;
  logic    p_ready;
  cordic_t p_data;

  // Rotator stages.
  logic [CORDIC_STAGES-1:0] c_valid;
  logic [CORDIC_STAGES-1:0] c_ready;
  cordic_t                  c_data [CORDIC_STAGES];

  // Scaling and wrap stages.
  logic              s_valid;
  logic              s_ready;
  logic [C_W-1:0]    s_centi;
  logic              s_same;
  logic              o_valid;
  logic              o_ready;
  logic [BEAR_W-1:0] o_bearing;
  logic              o_same;

  // Combinational next values.
  logic signed [DIFF_W-1:0] dlat_next;
  logic signed [DIFF_W-1:0] dlon_next;
  cordic_t                  p_next;
  logic signed [B_W-1:0]    b_val;
  logic [P_W-1:0]           prod;
  logic [C_W-1:0]           centi_next;
  logic [BEAR_W-1:0]        bearing_next;

  assign a_ready = !a_valid || p_ready;
  assign p_ready = !p_valid || c_ready[0];
  assign s_ready = !s_valid || o_ready;
  assign o_ready = !o_valid || result.ready;

  // No request is taken while reset is held.
  assign query.ready             = a_ready && !rst;
  assign result.valid            = o_valid;
  assign result.bearing_centideg = o_bearing;
  assign result.same_point       = o_same;

  always_comb begin
    dlat_next =
      DIFF_W'(to_arcsec(LON_DEG_W'(query.goal_lat_deg), query.goal_lat_min,
                        query.goal_lat_sec)) -
      DIFF_W'(to_arcsec(LON_DEG_W'(query.start_lat_deg), query.start_lat_min,
                        query.start_lat_sec));
    dlon_next =
      DIFF_W'(to_arcsec(query.goal_lon_deg, query.goal_lon_min, query.goal_lon_sec)) -
      DIFF_W'(to_arcsec(query.start_lon_deg, query.start_lon_min, query.start_lon_sec));
  end

  // A vector in the left half plane is turned by half a turn first, so the
  // rotator only has to cover the right half.
  always_comb begin
    p_next.x    = XY_W'(a_dlon) <<< SCALE_SHIFT;
    p_next.y    = XY_W'(a_dlat) <<< SCALE_SHIFT;
    p_next.z    = '0;
    p_next.same = a_same;
    if (a_dlon[DIFF_W-1]) begin
      p_next.x = -p_next.x;
      p_next.y = -p_next.y;
      p_next.z = a_dlat[DIFF_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      p_valid <= 1'b0;
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= query.valid;
      if (p_ready) p_valid <= a_valid;
      if (s_ready) s_valid <= c_valid[LAST];
      if (o_ready) o_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_dlat <= dlat_next;
      a_dlon <= dlon_next;
      a_same <= (dlat_next == '0) && (dlon_next == '0);
    end
    if (p_ready) begin
      p_data <= p_next;
    end
    if (s_ready) begin
      s_centi <= centi_next;
      s_same  <= c_data[LAST].same;
    end
    if (o_ready) begin
      o_bearing <= bearing_next;
      o_same    <= s_same;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    cordic_t src;
    cordic_t nxt;
    logic    src_valid;

    if (k == 0) begin : g_first
      assign src       = p_data;
      assign src_valid = p_valid;
    end else begin : g_chain
      assign src       = c_data[k-1];
      assign src_valid = c_valid[k-1];
    end

    if (k == LAST) begin : g_tail
      assign c_ready[k] = !c_valid[k] || s_ready;
    end else begin : g_body
      assign c_ready[k] = !c_valid[k] || c_ready[k+1];
    end

    // Drive y toward zero and accumulate the angle turned.
    always_comb begin
      nxt.same = src.same;
      if (!src.y[XY_W-1]) begin
        nxt.x = src.x + (src.y >>> k);
        nxt.y = src.y - (src.x >>> k);
        nxt.z = src.z + ATAN_TAB[k];
      end else begin
        nxt.x = src.x - (src.y >>> k);
        nxt.y = src.y + (src.x >>> k);
        nxt.z = src.z - ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid[k] <= 1'b0;
      end else if (c_ready[k]) begin
        c_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (c_ready[k]) c_data[k] <= nxt;
    end
  end

  // Bearing is 450 degrees minus the angle, which is always positive, then
  // rounded to centidegrees.
  always_comb begin
    b_val      = B_OFFSET - B_W'(c_data[LAST].z);
    prod       = P_W'(unsigned'(b_val)) * CENTI_MUL + ROUND_HALF;
    centi_next = prod[CENTI_SHIFT +: C_W];
  end

  // The rounded value stays below three full turns, so two compares wrap it.
  always_comb begin
    if (s_same) begin
      bearing_next = BEAR_SAME;
    end else if (s_centi >= TWO_TURNS) begin
      bearing_next = BEAR_W'(s_centi - TWO_TURNS);
    end else if (s_centi >= FULL_TURN) begin
      bearing_next = BEAR_W'(s_centi - FULL_TURN);
    end else begin
      bearing_next = BEAR_W'(s_centi);
    end
  end

endmodule
